// File: rtl/ctcg_pkg.sv
`default_nettype none

package ctcg_pkg;

   // Sizing
   localparam int unsigned VOCAB_MAX   = 64;
   localparam int unsigned ID_CAPACITY = 256;
   localparam int unsigned SIDX_W      = $clog2(VOCAB_MAX + 1);  // score index, stops at VOCAB_MAX
   localparam int unsigned BIDX_W      = $clog2(VOCAB_MAX);      // winning class index
   localparam int unsigned IDCNT_W     = $clog2(ID_CAPACITY + 1);

   // Result queue, depth must be a power of two
   localparam int unsigned RQ_DEPTH = 4;
   localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // FNV-1a 32
   localparam logic [31:0] HASH_OFFSET = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME  = 32'd16777619;

   localparam logic [15:0] FRAMES_MAX = 16'hFFFF;

   // Result kinds and status codes
   localparam logic ITEM_ID      = 1'b0;
   localparam logic ITEM_SUMMARY = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_TOO_LONG = 1'b1;

   typedef struct packed {
      logic signed [15:0] score;
      logic               frame_end;
      logic               utterance_end;
   } req_type;

   typedef struct packed {
      logic        item_type;
      logic [5:0]  phoneme_id;
      logic [31:0] hash_value;
      logic [15:0] frames_seen;
      logic [8:0]  ids_emitted;
      logic        status;
      logic        last_of_run;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/ctc_greedy_decoder_with_hash.sv
`default_nettype none
// Flow: an accepted beat waits in the input register and is decoded once two result-queue
//   entries are free; its results then enter the result queue, any summary after its id.
// Throughput: one score beat per cycle unless stalled; req stalls only while a beat is held
//   and over two of the four queue entries are full; a ready rsp does not prevent that.
// Reset (synchronous, active high): clears the argmax, counters and overflow flag, loads the
//   hash with the FNV-1a offset basis, and empties the input stage and result queue.

module ctc_greedy_decoder_with_hash (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  ctcg_pkg::req_type  req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output ctcg_pkg::rsp_type        rsp_payload
);

   // ---------------------------------------------------------------------------------------
   // Input stage: one registered beat
   // ---------------------------------------------------------------------------------------
   logic                   in_valid_ff, in_valid_in;
   ctcg_pkg::req_type      in_beat_ff;
   logic                   req_accept;
   logic                   advance;   // decode the held beat this cycle

   // ---------------------------------------------------------------------------------------
   // Per-utterance decoder state
   // ---------------------------------------------------------------------------------------
   logic signed [15:0]             best_score_ff, best_score_in;
   logic [ctcg_pkg::BIDX_W-1:0]    best_index_ff, best_index_in;
   logic [ctcg_pkg::SIDX_W-1:0]    score_index_ff, score_index_in;
   logic [ctcg_pkg::BIDX_W-1:0]    prev_winner_ff, prev_winner_in;
   logic                           prev_valid_ff, prev_valid_in;
   logic [31:0]                    hash_ff, hash_in;
   logic [15:0]                    frames_ff, frames_in;
   logic [ctcg_pkg::IDCNT_W-1:0]   ids_ff, ids_in;
   logic                           overflow_ff, overflow_in;

   // ---------------------------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------------------------
   ctcg_pkg::rsp_type              rq_ff [ctcg_pkg::RQ_DEPTH];
   logic [ctcg_pkg::RQ_PTR_W-1:0]  rq_wr_ff, rq_wr_in;
   logic [ctcg_pkg::RQ_PTR_W-1:0]  rq_rd_ff, rq_rd_in;
   logic [ctcg_pkg::RQ_CNT_W-1:0]  rq_cnt_ff, rq_cnt_in;
   logic [1:0]                     push_n;
   logic                           pop;
   ctcg_pkg::rsp_type              slot0, slot1;

   // Room for the worst case (two results) before decoding a beat.
   assign advance    = in_valid_ff &&
                       (rq_cnt_ff <= ctcg_pkg::RQ_CNT_W'(ctcg_pkg::RQ_DEPTH - 2));
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   assign rsp_valid   = (rq_cnt_ff != '0);
   assign rsp_payload = rq_ff[rq_rd_ff];
   assign pop         = rsp_valid && rsp_ready;

   // ---------------------------------------------------------------------------------------
   // Decode: argmax update, frame close, result build
   // ---------------------------------------------------------------------------------------
   always_comb begin
      logic                        fend;
      logic                        uend;
      logic                        in_range;
      logic [ctcg_pkg::BIDX_W-1:0] win;
      logic                        emit_id;
      ctcg_pkg::rsp_type           id_rsp;
      ctcg_pkg::rsp_type           sum_rsp;

      best_score_in  = best_score_ff;
      best_index_in  = best_index_ff;
      score_index_in = score_index_ff;
      prev_winner_in = prev_winner_ff;
      prev_valid_in  = prev_valid_ff;
      hash_in        = hash_ff;
      frames_in      = frames_ff;
      ids_in         = ids_ff;
      overflow_in    = overflow_ff;
      push_n         = 2'd0;
      emit_id        = 1'b0;
      fend           = in_beat_ff.frame_end;
      uend           = in_beat_ff.frame_end && in_beat_ff.utterance_end;
      in_range       = (score_index_ff < ctcg_pkg::SIDX_W'(ctcg_pkg::VOCAB_MAX));
      win            = '0;
      id_rsp         = '0;
      sum_rsp        = '0;
      slot0          = '0;
      slot1          = '0;

      if (advance) begin
         // Running argmax; first index wins ties, extra scores past the vocab are ignored.
         if (score_index_ff == '0) begin
            best_score_in = in_beat_ff.score;
            best_index_in = '0;
         end else if (in_range && (in_beat_ff.score > best_score_ff)) begin
            best_score_in = in_beat_ff.score;
            best_index_in = ctcg_pkg::BIDX_W'(score_index_ff);
         end
         if (in_range) begin
            score_index_in = score_index_ff + 1'b1;
         end

         if (fend) begin
            win            = best_index_in;
            score_index_in = '0;
            // After an overflow the rest of the utterance is dropped.
            if (!overflow_ff) begin
               hash_in = 32'((hash_ff ^ 32'(win)) * ctcg_pkg::HASH_PRIME);
               if (frames_ff != ctcg_pkg::FRAMES_MAX) begin
                  frames_in = frames_ff + 16'd1;
               end
               if ((win != '0) && (!prev_valid_ff || (win != prev_winner_ff))) begin
                  if (ids_ff < ctcg_pkg::IDCNT_W'(ctcg_pkg::ID_CAPACITY)) begin
                     ids_in  = ids_ff + 1'b1;
                     emit_id = 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               prev_winner_in = win;
               prev_valid_in  = 1'b1;
            end

            id_rsp.item_type   = ctcg_pkg::ITEM_ID;
            id_rsp.phoneme_id  = 6'(win);
            id_rsp.hash_value  = hash_in;
            id_rsp.frames_seen = frames_in;
            id_rsp.ids_emitted = 9'(ids_in);
            id_rsp.status      = overflow_in ? ctcg_pkg::STATUS_TOO_LONG : ctcg_pkg::STATUS_OK;
            id_rsp.last_of_run = !uend;

            sum_rsp             = id_rsp;
            sum_rsp.item_type   = ctcg_pkg::ITEM_SUMMARY;
            sum_rsp.phoneme_id  = '0;
            sum_rsp.last_of_run = 1'b1;

            if (emit_id && uend) begin
               push_n = 2'd2;
               slot0  = id_rsp;
               slot1  = sum_rsp;
            end else if (emit_id) begin
               push_n = 2'd1;
               slot0  = id_rsp;
            end else if (uend) begin
               push_n = 2'd1;
               slot0  = sum_rsp;
            end

            // Utterance done: back to the reset picture.
            if (uend) begin
               best_score_in  = '0;
               best_index_in  = '0;
               score_index_in = '0;
               prev_winner_in = '0;
               prev_valid_in  = 1'b0;
               hash_in        = ctcg_pkg::HASH_OFFSET;
               frames_in      = '0;
               ids_in         = '0;
               overflow_in    = 1'b0;
            end
         end
      end
   end

   // Queue pointers
   always_comb begin
      rq_wr_in  = rq_wr_ff + ctcg_pkg::RQ_PTR_W'(push_n);
      rq_rd_in  = rq_rd_ff + ctcg_pkg::RQ_PTR_W'(pop);
      rq_cnt_in = rq_cnt_ff + ctcg_pkg::RQ_CNT_W'(push_n) - ctcg_pkg::RQ_CNT_W'(pop);
   end

   // ---------------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         best_score_ff  <= '0;
         best_index_ff  <= '0;
         score_index_ff <= '0;
         prev_winner_ff <= '0;
         prev_valid_ff  <= 1'b0;
         hash_ff        <= ctcg_pkg::HASH_OFFSET;
         frames_ff      <= '0;
         ids_ff         <= '0;
         overflow_ff    <= 1'b0;
         rq_wr_ff       <= '0;
         rq_rd_ff       <= '0;
         rq_cnt_ff      <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         best_score_ff  <= best_score_in;
         best_index_ff  <= best_index_in;
         score_index_ff <= score_index_in;
         prev_winner_ff <= prev_winner_in;
         prev_valid_ff  <= prev_valid_in;
         hash_ff        <= hash_in;
         frames_ff      <= frames_in;
         ids_ff         <= ids_in;
         overflow_ff    <= overflow_in;
         rq_wr_ff       <= rq_wr_in;
         rq_rd_ff       <= rq_rd_in;
         rq_cnt_ff      <= rq_cnt_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_beat_ff <= req_payload;
      end
      if (push_n != 2'd0) begin
         rq_ff[rq_wr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         rq_ff[rq_wr_ff + 1'b1] <= slot1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      rq_cnt_ff <= ctcg_pkg::RQ_CNT_W'(ctcg_pkg::RQ_DEPTH))
      else $error("result queue count past depth");

   a_room_on_push: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> (rq_cnt_ff <= ctcg_pkg::RQ_CNT_W'(ctcg_pkg::RQ_DEPTH - 2)))
      else $error("push without room");

   a_sidx_bound: assert property (@(posedge clock) disable iff (reset)
      score_index_ff <= ctcg_pkg::SIDX_W'(ctcg_pkg::VOCAB_MAX))
      else $error("score index past vocab");

   a_summary_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.item_type == ctcg_pkg::ITEM_SUMMARY))
         |-> (rsp_payload.phoneme_id == '0) && rsp_payload.last_of_run)
      else $error("summary beat malformed");

   a_hash_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (hash_ff == ctcg_pkg::HASH_OFFSET) && (ids_ff == '0))
      else $error("state not cleared by reset");

endmodule

`default_nettype wire

// File: test/tb_ctc_greedy_decoder_with_hash.sv
`default_nettype none

module tb_ctc_greedy_decoder_with_hash;
   timeunit 1ns;
   timeprecision 1ps;

   import ctcg_pkg::*;

   // ------------------------------------------------------------------
   // Scoreboard: tracks the decoder state per accepted score beat and
   // keeps the results that are still owed on the rsp channel.
   // ------------------------------------------------------------------
   class decode_scoreboard;
      rsp_type            decoded_q[$];
      int unsigned        errors;

      logic signed [15:0] top_score;
      logic [5:0]         top_index;
      logic [6:0]         slot;          // next vocab index within the frame
      logic [5:0]         last_winner;
      logic               have_last;
      logic [31:0]        hash;
      logic [15:0]        frame_count;
      logic [8:0]         id_count;
      logic               truncated;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         top_score   = '0;
         top_index   = '0;
         slot        = '0;
         last_winner = '0;
         have_last   = 1'b0;
         hash        = HASH_OFFSET;
         frame_count = '0;
         id_count    = '0;
         truncated   = 1'b0;
      endfunction

      function rsp_type snapshot(logic kind, logic [5:0] id);
         rsp_type r;
         r.item_type   = kind;
         r.phoneme_id  = id;
         r.hash_value  = hash;
         r.frames_seen = frame_count;
         r.ids_emitted = id_count;
         r.status      = truncated ? STATUS_TOO_LONG : STATUS_OK;
         r.last_of_run = 1'b0;
         return r;
      endfunction

      // Greedy argmax plus FNV-1a fold; queues the id and/or summary beats.
      function void note_beat(req_type b);
         rsp_type    id_r;
         rsp_type    sum_r;
         logic       got_id;
         logic       uend;
         logic [5:0] w;
         got_id = 1'b0;
         uend   = b.frame_end & b.utterance_end;
         if (slot == 0) begin
            top_score = b.score;
            top_index = '0;
         end else if (slot < VOCAB_MAX && b.score > top_score) begin
            top_score = b.score;
            top_index = slot[5:0];
         end
         if (slot < VOCAB_MAX) slot++;
         if (b.frame_end) begin
            w    = top_index;
            slot = '0;
            if (!truncated) begin
               hash = (hash ^ {26'd0, w}) * HASH_PRIME;
               if (frame_count < FRAMES_MAX) frame_count++;
               if (w != 0 && (!have_last || w != last_winner)) begin
                  if (id_count < ID_CAPACITY) begin
                     id_count++;
                     id_r   = snapshot(ITEM_ID, w);
                     got_id = 1'b1;
                  end else begin
                     truncated = 1'b1;
                  end
               end
               last_winner = w;
               have_last   = 1'b1;
            end
            if (got_id) begin
               id_r.last_of_run = !uend;
               decoded_q.push_back(id_r);
            end
            if (uend) begin
               sum_r = snapshot(ITEM_SUMMARY, 6'd0);
               sum_r.last_of_run = 1'b1;
               decoded_q.push_back(sum_r);
               restart();
            end
         end
      endfunction

      function string show(rsp_type r);
         return $sformatf("type=%0d id=%0d hash=%08h frames=%0d ids=%0d status=%0d last=%0d",
                          r.item_type, r.phoneme_id, r.hash_value, r.frames_seen,
                          r.ids_emitted, r.status, r.last_of_run);
      endfunction

      function void check_beat(rsp_type got);
         rsp_type want;
         if (decoded_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("tb: unexpected result beat: %s", show(got));
            return;
         end
         want = decoded_q.pop_front();
         if (got.item_type !== want.item_type || got.phoneme_id !== want.phoneme_id ||
             got.hash_value !== want.hash_value || got.frames_seen !== want.frames_seen ||
             got.ids_emitted !== want.ids_emitted || got.status !== want.status ||
             got.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= 10) begin
               $display("tb: mismatch at %0t", $realtime);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   always #4 clock = ~clock;

   ctc_greedy_decoder_with_hash i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   decode_scoreboard sb;

   // ------------------------------------------------------------------
   // Result side: check every accepted beat, stall with a pattern that
   // redraws its mode when the low byte of rx_cycle wraps (always ready,
   // coin flip, sparse, periodic window).
   // ------------------------------------------------------------------
   logic [31:0] rx_cycle = '0;
   int          stall_mode = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_beat(rsp_payload);
      rx_cycle = rx_cycle + 1;
      if (rx_cycle[7:0] == 8'd0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (rx_cycle[3:0] < 4'd3);
      endcase
   end

   // ------------------------------------------------------------------
   // Score side: bursts of random length with random gaps.
   // ------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_beat(input req_type b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      if (burst_left > 0) burst_left--;
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(b);
   endtask

   task automatic drive(input logic [15:0] s, input logic fe, input logic ue);
      send_beat(req_type'{score: s, frame_end: fe, utterance_end: ue});
   endtask

   // Lower valid and hold off until every owed result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.decoded_q.size() != 0);
   endtask

   function automatic logic [15:0] rand_score();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return 16'($urandom_range(0, 4) - 2);   // small values, lots of ties
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // One frame of 'len' scores whose argmax lands on index 'win' (win < len, < VOCAB_MAX).
   // Later scores may tie the peak, earlier ones stay below it. Stray utterance
   // marks without a frame mark are sprinkled in; they must be ignored.
   task automatic send_frame(input int len, input int win, input bit ue);
      int peak;
      int s;
      peak = ($urandom_range(0, 9) == 0) ? 32767 : int'($urandom_range(0, 65534)) - 32767;
      for (int i = 0; i < len; i++) begin
         if (i == win)     s = peak;
         else if (i < win) s = int'($urandom_range(0, peak + 32767)) - 32768;
         else              s = int'($urandom_range(0, peak + 32768)) - 32768;
         drive(s[15:0], i == len - 1, (i == len - 1) ? ue : ($urandom_range(0, 7) == 0));
      end
   endtask

   // Well-formed utterance: mixed frame lengths (some past VOCAB_MAX), blanks,
   // repeated winners and fresh winners.
   task automatic random_utterance(inout int count);
      int nframes;
      int len;
      int win;
      int prev;
      int lim;
      nframes = $urandom_range(1, 24);
      prev    = 0;
      for (int f = 0; f < nframes; f++) begin
         case ($urandom_range(0, 19)) inside
            [0:11]:  len = $urandom_range(1, 8);
            [12:17]: len = $urandom_range(1, VOCAB_MAX);
            default: len = $urandom_range(VOCAB_MAX + 1, VOCAB_MAX + 8);
         endcase
         lim = (len < VOCAB_MAX) ? len : VOCAB_MAX;
         case ($urandom_range(0, 5))
            0: win = 0;
            1: win = (prev < len) ? prev : 0;
            default: win = $urandom_range(0, lim - 1);
         endcase
         send_frame(len, win, f == nframes - 1);
         count += len;
         prev = win;
      end
   endtask

   // Utterance that runs past the id capacity: winners alternate 1/2 so every
   // frame wants an id; 'extra' frames follow the one that overflows.
   task automatic long_utterance(input int extra, inout int count);
      int nframes;
      int win;
      int len;
      nframes = ID_CAPACITY + 1 + extra;
      for (int f = 0; f < nframes; f++) begin
         win = 1 + (f % 2);
         len = win + 1 + $urandom_range(0, 1);
         send_frame(len, win, f == nframes - 1);
         count += len;
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int count;
      sb = new();
      count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, ties, blanks, repeats, stray utterance mark,
      // id and summary from the same beat.
      drive(16'h8000, 1'b1, 1'b1);                               // lone blank frame
      drive(16'h8000, 1'b0, 1'b0); drive(16'h7FFF, 1'b1, 1'b0);  // id 1
      drive(16'h0000, 1'b0, 1'b0); drive(16'h7FFF, 1'b1, 1'b0);  // repeat, no id
      drive(16'h0005, 1'b0, 1'b0); drive(16'h0005, 1'b0, 1'b0);
      drive(16'h0005, 1'b1, 1'b0);                               // tie, blank wins
      drive(16'hFFFF, 1'b0, 1'b0); drive(16'h0000, 1'b0, 1'b0);
      drive(16'h0000, 1'b1, 1'b0);                               // id 1 again after blank
      drive(16'hFFFB, 1'b0, 1'b1);                               // ignored utterance mark
      drive(16'hFFFA, 1'b0, 1'b0); drive(16'h8000, 1'b1, 1'b0);  // negative first score wins
      drive(16'h0000, 1'b0, 1'b0); drive(16'h0001, 1'b0, 1'b0);
      drive(16'h0002, 1'b1, 1'b1);                               // id 2 plus summary
      drive(16'h0100, 1'b1, 1'b0);
      drive(16'h8000, 1'b0, 1'b0); drive(16'h7FFF, 1'b0, 1'b0);
      drive(16'h7FFF, 1'b1, 1'b1);                               // tie at max, id 1 + summary
      drain();

      // Random: capacity overflow with trailing frames, then mixed utterances
      // and noise, a full hold-off midway, and an overflow on the final frame.
      long_utterance($urandom_range(1, 6), count);
      while (count < 1650) begin
         if ($urandom_range(0, 9) == 0) begin
            for (int n = $urandom_range(1, 20); n > 0; n--) begin
               drive(rand_score(), $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
               count++;
            end
         end else begin
            random_utterance(count);
         end
         if (count >= 1100 && count < 1400) begin
            drain();
            long_utterance(0, count);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #(10_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
